FILE: rtl/fsqcd_pkg.sv
// Shared types, constants and the micro-program of the fraction sum/quotient core.
`timescale 1ns / 1ps

package fsqcd_pkg;

  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned OUT_W          = 32;
  localparam int unsigned SUM_W          = 33;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_MUL,
    OP_DIV,
    OP_GCD
  } op_e;

  // Scratch register file entries.
  typedef enum logic [4:0] {
    R_N1, R_D1, R_N2, R_D2,
    R_RN1, R_RD1, R_RN2, R_RD2,
    R_G, R_T, R_U,
    R_C0, R_C1, R_LCM,
    R_P, R_Q, R_SN, R_SD, R_QN, R_QD
  } reg_e;

  localparam int unsigned NUM_REGS = 20;

  typedef struct packed {
    op_e  op;
    reg_e a;
    reg_e b;
    reg_e dst;
  } uop_t;

  localparam int unsigned PROG_LEN = 23;
  localparam int unsigned PC_W     = $clog2(PROG_LEN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_READ,
    S_START,
    S_DIV,
    S_MUL,
    S_WB,
    S_DONE
  } state_e;

  // Fixed instruction sequence for one item.
  function automatic uop_t prog_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:    u = '{OP_GCD, R_N1,  R_D1,  R_G};
      5'd1:    u = '{OP_DIV, R_N1,  R_G,   R_RN1};
      5'd2:    u = '{OP_DIV, R_D1,  R_G,   R_RD1};
      5'd3:    u = '{OP_GCD, R_N2,  R_D2,  R_G};
      5'd4:    u = '{OP_DIV, R_N2,  R_G,   R_RN2};
      5'd5:    u = '{OP_DIV, R_D2,  R_G,   R_RD2};
      5'd6:    u = '{OP_GCD, R_RD1, R_RD2, R_G};
      5'd7:    u = '{OP_DIV, R_RD1, R_G,   R_T};
      5'd8:    u = '{OP_DIV, R_RD2, R_G,   R_U};
      5'd9:    u = '{OP_MUL, R_RN1, R_U,   R_C0};
      5'd10:   u = '{OP_MUL, R_RN2, R_T,   R_C1};
      5'd11:   u = '{OP_MUL, R_T,   R_RD2, R_LCM};
      5'd12:   u = '{OP_MUL, R_N1,  R_D2,  R_P};
      5'd13:   u = '{OP_MUL, R_N2,  R_D1,  R_Q};
      5'd14:   u = '{OP_ADD, R_P,   R_Q,   R_SN};
      5'd15:   u = '{OP_MUL, R_D1,  R_D2,  R_SD};
      5'd16:   u = '{OP_GCD, R_SN,  R_SD,  R_G};
      5'd17:   u = '{OP_DIV, R_SN,  R_G,   R_SN};
      5'd18:   u = '{OP_DIV, R_SD,  R_G,   R_SD};
      5'd19:   u = '{OP_MUL, R_D1,  R_N2,  R_QD};
      5'd20:   u = '{OP_GCD, R_P,   R_QD,  R_G};
      5'd21:   u = '{OP_DIV, R_P,   R_G,   R_QN};
      5'd22:   u = '{OP_DIV, R_QD,  R_G,   R_QD};
      default: u = '{OP_ADD, R_N1,  R_N1,  R_G};
    endcase
    return u;
  endfunction

endpackage

FILE: rtl/fsqcd_in_if.sv
// Input channel: a pair of fractions with valid/ready handshake.
`timescale 1ns / 1ps

interface fsqcd_in_if #(
  parameter int unsigned VALUE_BITS = fsqcd_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] first_num;
  logic [VALUE_BITS-1:0] first_den;
  logic [VALUE_BITS-1:0] second_num;
  logic [VALUE_BITS-1:0] second_den;

  modport source (output valid, first_num, first_den, second_num, second_den, input ready);
  modport sink   (input valid, first_num, first_den, second_num, second_den, output ready);
endinterface

FILE: rtl/fsqcd_out_if.sv
// Output channel: common-denominator, sum and quotient results.
`timescale 1ns / 1ps

interface fsqcd_out_if;
  logic                         valid;
  logic                         ready;
  logic [fsqcd_pkg::OUT_W-1:0]  common_first_num;
  logic [fsqcd_pkg::OUT_W-1:0]  common_second_num;
  logic [fsqcd_pkg::OUT_W-1:0]  common_den;
  logic [fsqcd_pkg::SUM_W-1:0]  sum_num;
  logic [fsqcd_pkg::OUT_W-1:0]  sum_den;
  logic [fsqcd_pkg::OUT_W-1:0]  quot_num;
  logic [fsqcd_pkg::OUT_W-1:0]  quot_den;
  logic                         div_by_zero;

  modport source (output valid, common_first_num, common_second_num, common_den, sum_num,
                  sum_den, quot_num, quot_den, div_by_zero, input ready);
  modport sink   (input valid, common_first_num, common_second_num, common_den, sum_num,
                  sum_den, quot_num, quot_den, div_by_zero, output ready);
endinterface

FILE: rtl/fraction_sum_quotient_common_den_core.sv
// One item at a time: the micro-program runs each step on the shared unit, which multiplies
//   by shift-and-add and divides bit-serially; the next item is taken back in idle.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops output valid.
`timescale 1ns / 1ps

module fraction_sum_quotient_common_den_core #(
  parameter int unsigned VALUE_BITS = fsqcd_pkg::VALUE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fsqcd_in_if.sink     in_i,
  fsqcd_out_if.source  out_o
);
  import fsqcd_pkg::*;

  // Internal width: wide enough for a full product sum and for the widest output field.
  localparam int unsigned XW = ((2 * VALUE_BITS + 1) > SUM_W) ? (2 * VALUE_BITS + 1) : SUM_W;
  localparam int unsigned CW = $clog2(XW + 1);

  // Sequencer state and micro-program counter.
  state_e          state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [1:0]      ld_cnt_q, ld_cnt_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  uop_t            uop;

  // Captured operands of the item.
  logic [VALUE_BITS-1:0] n1_q, d1_q, n2_q, d2_q;
  logic                  dz_q;

  // Shared arithmetic unit: x/y are operands, acc is product accumulator or partial
  // remainder, quo shifts the dividend out and the quotient in.
  logic [XW-1:0] x_q, x_d, y_q, y_d, acc_q, acc_d, quo_q, quo_d, res_q, res_d;
  logic [XW:0]   trial, diff;
  logic          ge;
  logic [XW-1:0] mul_sum;

  // Scratch register file, read through registered ports.
  logic [XW-1:0] mem_q [NUM_REGS];
  logic [XW-1:0] rd_a_q, rd_b_q;
  logic          wr_en;
  reg_e          wr_addr;
  logic [XW-1:0] wr_data;

  // Working copies of the results and the output register.
  logic [XW-1:0] w_c0_q, w_c1_q, w_lcm_q, w_sn_q, w_sd_q, w_qn_q, w_qd_q;
  logic [XW-1:0] o_c0_q, o_c1_q, o_lcm_q, o_sn_q, o_sd_q, o_qn_q, o_qd_q;
  logic          o_dz_q;
  logic          out_valid_q, out_valid_d;
  logic          in_fire, out_load;

  assign uop     = prog_rom(pc_q);
  assign in_fire = in_i.valid && in_i.ready;

  // A restoring divide step: shift one dividend bit into the remainder, subtract if it fits.
  assign trial   = {acc_q, quo_q[XW-1]};
  assign diff    = trial - {1'b0, y_q};
  assign ge      = !diff[XW];
  assign mul_sum = acc_q + x_q;

  // The finished item moves to the output register once that register is free.
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_LOAD;
      end
      S_LOAD: begin
        if (ld_cnt_q == 2'd3) state_d = S_READ;
      end
      S_READ: state_d = S_START;
      S_START: begin
        case (uop.op)
          OP_ADD:  state_d = S_WB;
          OP_MUL:  state_d = S_MUL;
          OP_DIV:  state_d = S_DIV;
          OP_GCD:  state_d = (rd_b_q == '0) ? S_WB : S_DIV;
          default: state_d = S_WB;
        endcase
      end
      S_MUL: begin
        if (cnt_q == '0) state_d = S_WB;
      end
      S_DIV: begin
        if (cnt_q == '0) begin
          if (uop.op != OP_GCD || acc_q == '0) state_d = S_WB;
        end
      end
      S_WB: begin
        state_d = (pc_q == PC_W'(PROG_LEN - 1)) ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and sequencer outputs.
  always_comb begin
    pc_d        = pc_q;
    ld_cnt_d    = ld_cnt_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    y_d         = y_q;
    acc_d       = acc_q;
    quo_d       = quo_q;
    res_d       = res_q;
    wr_en       = 1'b0;
    wr_addr     = uop.dst;
    wr_data     = res_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;

    case (state_q)
      S_IDLE: begin
        ld_cnt_d = '0;
        pc_d     = '0;
      end
      S_LOAD: begin
        wr_en    = 1'b1;
        ld_cnt_d = ld_cnt_q + 2'd1;
        case (ld_cnt_q)
          2'd0:    begin wr_addr = R_N1; wr_data = XW'(n1_q); end
          2'd1:    begin wr_addr = R_D1; wr_data = XW'(d1_q); end
          2'd2:    begin wr_addr = R_N2; wr_data = XW'(n2_q); end
          default: begin wr_addr = R_D2; wr_data = XW'(d2_q); end
        endcase
      end
      S_START: begin
        x_d   = rd_a_q;
        y_d   = rd_b_q;
        acc_d = '0;
        case (uop.op)
          OP_ADD: res_d = rd_a_q + rd_b_q;
          OP_MUL: cnt_d = CW'(VALUE_BITS);
          OP_DIV: begin
            quo_d = rd_a_q;
            cnt_d = CW'(XW);
          end
          OP_GCD: begin
            // gcd(0, 0) is taken as 1 so that later divides stay defined.
            res_d = (rd_a_q == '0) ? XW'(1) : rd_a_q;
            quo_d = rd_a_q;
            cnt_d = CW'(XW);
          end
          default: res_d = '0;
        endcase
      end
      S_MUL: begin
        if (cnt_q == '0) begin
          res_d = acc_q;
        end else begin
          if (y_q[0]) acc_d = mul_sum;
          x_d   = x_q << 1;
          y_d   = y_q >> 1;
          cnt_d = cnt_q - CW'(1);
        end
      end
      S_DIV: begin
        if (cnt_q != '0) begin
          acc_d = ge ? diff[XW-1:0] : trial[XW-1:0];
          quo_d = {quo_q[XW-2:0], ge};
          cnt_d = cnt_q - CW'(1);
        end else if (uop.op == OP_GCD) begin
          // One Euclid step: (x, y) becomes (y, x mod y).
          x_d   = y_q;
          y_d   = acc_q;
          res_d = y_q;
          quo_d = y_q;
          acc_d = '0;
          cnt_d = CW'(XW);
        end else begin
          res_d = quo_q;
        end
      end
      S_WB: begin
        wr_en = 1'b1;
        pc_d  = pc_q + PC_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      ld_cnt_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      ld_cnt_q    <= ld_cnt_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    quo_q <= quo_d;
    res_q <= res_d;
    if (in_fire) begin
      // A zero denominator is taken as one.
      n1_q <= in_i.first_num;
      d1_q <= (in_i.first_den == '0) ? VALUE_BITS'(1) : in_i.first_den;
      n2_q <= in_i.second_num;
      d2_q <= (in_i.second_den == '0) ? VALUE_BITS'(1) : in_i.second_den;
      dz_q <= (in_i.second_num == '0);
    end
    if (state_q == S_WB) begin
      case (uop.dst)
        R_C0:    w_c0_q  <= res_q;
        R_C1:    w_c1_q  <= res_q;
        R_LCM:   w_lcm_q <= res_q;
        R_SN:    w_sn_q  <= res_q;
        R_SD:    w_sd_q  <= res_q;
        R_QN:    w_qn_q  <= res_q;
        R_QD:    w_qd_q  <= res_q;
        default: ;
      endcase
    end
    if (out_load) begin
      o_c0_q  <= w_c0_q;
      o_c1_q  <= w_c1_q;
      o_lcm_q <= w_lcm_q;
      o_sn_q  <= w_sn_q;
      o_sd_q  <= w_sd_q;
      o_qn_q  <= dz_q ? '0 : w_qn_q;
      o_qd_q  <= dz_q ? '0 : w_qd_q;
      o_dz_q  <= dz_q;
    end
  end

  // Register file: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_a_q <= mem_q[uop.a];
    rd_b_q <= mem_q[uop.b];
  end

  assign in_i.ready              = (state_q == S_IDLE);
  assign out_o.valid             = out_valid_q;
  assign out_o.common_first_num  = o_c0_q[OUT_W-1:0];
  assign out_o.common_second_num = o_c1_q[OUT_W-1:0];
  assign out_o.common_den        = o_lcm_q[OUT_W-1:0];
  assign out_o.sum_num           = o_sn_q[SUM_W-1:0];
  assign out_o.sum_den           = o_sd_q[OUT_W-1:0];
  assign out_o.quot_num          = o_qn_q[OUT_W-1:0];
  assign out_o.quot_den          = o_qd_q[OUT_W-1:0];
  assign out_o.div_by_zero       = o_dz_q;

endmodule

FILE: rtl/fsqcd_checker.sv
// Port-level checks of the fraction sum/quotient core, bound to the top level.
`timescale 1ns / 1ps

module fsqcd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [fsqcd_pkg::SUM_W-1:0]  sum_num_i,
  input logic [fsqcd_pkg::OUT_W-1:0]  sum_den_i,
  input logic [fsqcd_pkg::OUT_W-1:0]  common_den_i,
  input logic [fsqcd_pkg::OUT_W-1:0]  quot_num_i,
  input logic [fsqcd_pkg::OUT_W-1:0]  quot_den_i,
  input logic                         dz_i
);
  import fsqcd_pkg::*;

  // The core works on one item at a time.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while an item is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(sum_num_i)))
    else $error("stalled result dropped or changed");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && dz_i) |-> (quot_num_i == '0 && quot_den_i == '0))
    else $error("quotient not cleared on divide by zero");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (sum_den_i != '0 && common_den_i != '0))
    else $error("zero denominator in result");

endmodule

bind fraction_sum_quotient_common_den_core fsqcd_checker u_fsqcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .sum_num_i    (out_o.sum_num),
  .sum_den_i    (out_o.sum_den),
  .common_den_i (out_o.common_den),
  .quot_num_i   (out_o.quot_num),
  .quot_den_i   (out_o.quot_den),
  .dz_i         (out_o.div_by_zero)
);

FILE: verif/tb_fraction_sum_quotient_common_den_core.sv
// Self-checking testbench for the fraction sum, quotient and common denominator core.
`timescale 1ns / 1ps

module tb_fraction_sum_quotient_common_den_core;
  import fsqcd_pkg::*;

  // Expected fields of one result transfer.
  typedef struct packed {
    logic [OUT_W-1:0] c1;
    logic [OUT_W-1:0] c2;
    logic [OUT_W-1:0] cden;
    logic [SUM_W-1:0] snum;
    logic [OUT_W-1:0] sden;
    logic [OUT_W-1:0] qnum;
    logic [OUT_W-1:0] qden;
    logic             dz;
  } frac_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  fsqcd_in_if  fin ();
  fsqcd_out_if fout ();

  fraction_sum_quotient_common_den_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (fin.sink),
    .out_o  (fout.source)
  );

  // Results that the block still owes, oldest first.
  frac_result_t pending_results[$];
  int  err_count   = 0;
  longint cycle_count = 0;
  int  send_idle_pct = 0;   // Chance in percent, per try, that the sender holds off.
  int  recv_stall_pct = 0;  // Chance in percent that the receiver holds off.
  bit  hold_off = 1'b0;     // Forces the receiver to stall for a long stretch.

  // Generous limit: about 1700 items, with stalls on top.
  localparam longint CYCLE_LIMIT = 64'd60_000_000;

  initial begin
    fin.valid = 1'b0;
    fin.first_num = '0;
    fin.first_den = 16'd1;
    fin.second_num = '0;
    fin.second_den = 16'd1;
    fout.ready = 1'b0;
  end

  function automatic logic [63:0] gcd64(input logic [63:0] p, input logic [63:0] q);
    logic [63:0] r;
    while (q != 0) begin
      r = p % q;
      p = q;
      q = r;
    end
    return p;
  endfunction

  // Works out the reduced common-denominator form, the sum and the quotient.
  function automatic frac_result_t fraction_results(input logic [15:0] n1_i,
                                                    input logic [15:0] d1_i,
                                                    input logic [15:0] n2_i,
                                                    input logic [15:0] d2_i);
    frac_result_t res;
    logic [63:0] n1, d1, n2, d2, rn1, rd1, rn2, rd2, g, lcm, sn, sd, qn, qd;
    n1 = n1_i;
    d1 = (d1_i == 0) ? 64'd1 : d1_i;
    n2 = n2_i;
    d2 = (d2_i == 0) ? 64'd1 : d2_i;
    g = gcd64(n1, d1);
    rn1 = n1 / g;
    rd1 = d1 / g;
    g = gcd64(n2, d2);
    rn2 = n2 / g;
    rd2 = d2 / g;
    g = gcd64(rd1, rd2);
    lcm = (rd1 / g) * rd2;
    res.c1 = 32'(rn1 * (lcm / rd1));
    res.c2 = 32'(rn2 * (lcm / rd2));
    res.cden = 32'(lcm);
    sn = n1 * d2 + n2 * d1;
    sd = d1 * d2;
    g = gcd64(sn, sd);
    res.snum = 33'(sn / g);
    res.sden = 32'(sd / g);
    res.dz = (n2 == 0);
    if (res.dz) begin
      qn = 0;
      qd = 0;
    end else begin
      qn = n1 * d2;
      qd = d1 * n2;
      g = gcd64(qn, qd);
      qn = qn / g;
      qd = qd / g;
    end
    res.qnum = 32'(qn);
    res.qden = 32'(qd);
    return res;
  endfunction

  // Offers one fraction pair and waits for its transfer, with random idle cycles first.
  // Valid stays up after a transfer until the next call idles or wait_drained drops it.
  task automatic send_pair(input logic [15:0] n1, input logic [15:0] d1,
                           input logic [15:0] n2, input logic [15:0] d2);
    while ($urandom_range(99) < send_idle_pct) begin
      fin.valid <= 1'b0;
      @(posedge clk_i);
    end
    fin.valid <= 1'b1;
    fin.first_num <= n1;
    fin.first_den <= d1;
    fin.second_num <= n2;
    fin.second_den <= d2;
    pending_results.push_back(fraction_results(n1, d1, n2, d2));
    do @(posedge clk_i); while (!fin.ready);
  endtask

  task automatic wait_drained();
    fin.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_den();
    return 16'($urandom_range(65535, 1));
  endfunction

  // Half of the values small so that reductions and shared factors are common.
  function automatic logic [15:0] rand_value();
    case ($urandom_range(3))
      0: return 16'($urandom_range(12));
      1: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    send_pair(16'd0, 16'd1, 16'd0, 16'd1);
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pair(16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
    send_pair(16'd1, 16'hFFFF, 16'd1, 16'hFFFE);
    send_pair(16'hFFFF, 16'd1, 16'd1, 16'hFFFF);
    send_pair(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    send_pair(16'd0, 16'd0, 16'd5, 16'd0);
    send_pair(16'd7, 16'd0, 16'd3, 16'd9);
    wait_drained();
  endtask

  task automatic test_zero_numerators();
    send_pair(16'd0, 16'd7, 16'd3, 16'd4);
    send_pair(16'd6, 16'd4, 16'd0, 16'd9);
    send_pair(16'd0, 16'd12, 16'd0, 16'd18);
    wait_drained();
  endtask

  task automatic test_reductions();
    send_pair(16'd6, 16'd8, 16'd9, 16'd12);
    send_pair(16'd1, 16'd2, 16'd1, 16'd2);
    send_pair(16'd2, 16'd3, 16'd3, 16'd2);
    send_pair(16'd12, 16'd18, 16'd20, 16'd30);
    send_pair(16'd1, 16'd3, 16'd2, 16'd3);
    send_pair(16'd65521, 16'd65519, 16'd65497, 16'd65521);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    logic [15:0] n1, d1, n2, d2;
    for (int i = 0; i < count; i++) begin
      n1 = rand_value();
      n2 = ($urandom_range(15) == 0) ? 16'd0 : rand_value();
      d1 = ($urandom_range(1)) ? rand_den() : 16'($urandom_range(64, 1));
      d2 = ($urandom_range(1)) ? rand_den() : 16'($urandom_range(64, 1));
      send_pair(n1, d1, n2, d2);
    end
    wait_drained();
  endtask

  // The receiver stalls for a long stretch while items keep coming, so the
  // input stalls; then the sender pauses until all results have drained.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (6000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random(4);
    join
    wait_drained();
  endtask

  // Receiver side: random stalls, each transfer checked against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fout.ready <= 1'b0;
    end else begin
      if (fout.valid && fout.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          err_count++;
        end else begin
          frac_result_t exp_r;
          exp_r = pending_results.pop_front();
          if (fout.common_first_num !== exp_r.c1) begin
            $error("common_first_num exp %0d got %0d", exp_r.c1, fout.common_first_num);
            err_count++;
          end
          if (fout.common_second_num !== exp_r.c2) begin
            $error("common_second_num exp %0d got %0d", exp_r.c2, fout.common_second_num);
            err_count++;
          end
          if (fout.common_den !== exp_r.cden) begin
            $error("common_den exp %0d got %0d", exp_r.cden, fout.common_den);
            err_count++;
          end
          if (fout.sum_num !== exp_r.snum) begin
            $error("sum_num exp %0d got %0d", exp_r.snum, fout.sum_num);
            err_count++;
          end
          if (fout.sum_den !== exp_r.sden) begin
            $error("sum_den exp %0d got %0d", exp_r.sden, fout.sum_den);
            err_count++;
          end
          if (fout.quot_num !== exp_r.qnum) begin
            $error("quot_num exp %0d got %0d", exp_r.qnum, fout.quot_num);
            err_count++;
          end
          if (fout.quot_den !== exp_r.qden) begin
            $error("quot_den exp %0d got %0d", exp_r.qden, fout.quot_den);
            err_count++;
          end
          if (fout.div_by_zero !== exp_r.dz) begin
            $error("div_by_zero exp %0d got %0d", exp_r.dz, fout.div_by_zero);
            err_count++;
          end
        end
      end
      fout.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_zero_numerators();
    test_reductions();
    test_backpressure();
    test_random(450);
    send_idle_pct = 45;
    test_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 45;
    test_random(400);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    test_random(420);
    repeat (100) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: fraction_sum_quotient_common_den_core.f
rtl/fsqcd_pkg.sv
rtl/fsqcd_in_if.sv
rtl/fsqcd_out_if.sv
rtl/fraction_sum_quotient_common_den_core.sv
rtl/fsqcd_checker.sv
verif/tb_fraction_sum_quotient_common_den_core.sv
